/* sv/sd_spi_command_response_engine_unit_macros.svh */
`ifndef SD_SPI_COMMAND_RESPONSE_ENGINE_UNIT_MACROS_SVH
`define SD_SPI_COMMAND_RESPONSE_ENGINE_UNIT_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define SDSPI_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sdspi check failed");

// next-cycle implication, sampled on clk, off during reset
`define SDSPI_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sdspi check failed");

`endif

/* sv/sdspi_pkg.sv */
package sdspi_pkg;

  localparam int unsigned MAX_PAYLOAD_BYTES_DEF = 512;
  localparam int unsigned PLEN_W    = 10;
  localparam int unsigned TRIES_W   = 10;
  localparam int unsigned FRAME_LEN = 6;
  localparam int unsigned CNT_W     = 3;
  localparam int unsigned MSG_W     = 40;
  localparam int unsigned CRC_W     = 7;

  localparam logic [TRIES_W-1:0] RESP_TRIES_RESET = 10'd200;
  localparam logic [7:0] CMD_START   = 8'h40;
  localparam logic [7:0] R1_BUSY_BIT = 8'h80;
  localparam logic [7:0] DATA_TOKEN  = 8'hfe;
  localparam logic [7:0] DRESP_MASK  = 8'h11;
  localparam logic [7:0] DRESP_MARK  = 8'h01;
  localparam logic [7:0] DRESP_CODE  = 8'h1f;
  localparam logic [7:0] DRESP_OK    = 8'h05;
  localparam logic [7:0] CRC7_POLY   = 8'h09;

  typedef enum logic [1:0] {
    OP_ISSUE = 2'd0,
    OP_RX    = 2'd1,
    OP_WRESP = 2'd2,
    OP_NOP   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    KIND_TX      = 3'd0,
    KIND_R1      = 3'd1,
    KIND_DATA    = 3'd2,
    KIND_TIMEOUT = 3'd3,
    KIND_REJECT  = 3'd4,
    KIND_DONE    = 3'd5
  } kind_t;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_R1      = 3'd1,
    PH_TOKEN   = 3'd2,
    PH_PAYLOAD = 3'd3,
    PH_CRC     = 3'd4,
    PH_DRESP   = 3'd5,
    PH_BUSY    = 3'd6
  } phase_t;

  typedef struct packed {
    logic [1:0]        op;
    logic [5:0]        cmd_index;
    logic [31:0]       cmd_arg;
    logic [PLEN_W-1:0] payload_len;
    logic              with_token;
    logic [7:0]        rx_byte;
  } in_item_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  out_byte;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [CNT_W-1:0]            count;
    out_item_t [FRAME_LEN-1:0]   words;
  } batch_t;

  // CRC7 is linear: column j is the CRC of a message with only bit j set
  // (bit 39 goes out first).
  function automatic logic [MSG_W*CRC_W-1:0] crc7_cols();
    logic [MSG_W*CRC_W-1:0] cols;
    logic [MSG_W-1:0]       d;
    logic [7:0]             acc;
    int                     j;
    int                     k;
    cols = '0;
    for (j = 0; j < MSG_W; j++) begin
      d   = MSG_W'(1) << j;
      acc = '0;
      for (k = MSG_W - 1; k >= 0; k--) begin
        acc = {acc[6:0], 1'b0};
        if (d[k] ^ acc[7]) begin
          acc = acc ^ CRC7_POLY;
        end
      end
      cols[j*CRC_W +: CRC_W] = acc[CRC_W-1:0];
    end
    return cols;
  endfunction

  localparam logic [MSG_W*CRC_W-1:0] CRC7_COLS = crc7_cols();

endpackage

/* sv/sdspi_crc7.sv */
module sdspi_crc7 (
  input  logic [5:0]  cmd_index,
  input  logic [31:0] cmd_arg,
  output logic [7:0]  crc_byte
);

  logic [sdspi_pkg::MSG_W-1:0] msg;
  logic [sdspi_pkg::CRC_W-1:0] crc;

  assign msg = {sdspi_pkg::CMD_START | {2'b00, cmd_index}, cmd_arg};

  always_comb begin
    crc = '0;
    for (int j = 0; j < sdspi_pkg::MSG_W; j++) begin
      if (msg[j]) begin
        crc = crc ^ sdspi_pkg::CRC7_COLS[j*sdspi_pkg::CRC_W +: sdspi_pkg::CRC_W];
      end
    end
  end

  assign crc_byte = {crc, 1'b1};

endmodule

/* sv/sdspi_ctrl.sv */
module sdspi_ctrl #(
  parameter int unsigned MAX_PAYLOAD_BYTES = sdspi_pkg::MAX_PAYLOAD_BYTES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [sdspi_pkg::TRIES_W-1:0]    cfg_wdata,
  input  logic                             go,
  input  sdspi_pkg::in_item_t              item,
  input  logic [7:0]                       crc_byte,
  output sdspi_pkg::batch_t                batch
);

  localparam int unsigned BL_W  = $clog2(MAX_PAYLOAD_BYTES + 1);
  localparam int unsigned CMP_W = (BL_W > sdspi_pkg::PLEN_W) ? BL_W : sdspi_pkg::PLEN_W;
  localparam logic [CMP_W-1:0] MAX_CMP = CMP_W'(MAX_PAYLOAD_BYTES);

  sdspi_pkg::phase_t              phase_r, phase_nxt;
  logic [sdspi_pkg::TRIES_W-1:0]  tries_r, tries_nxt;
  logic [sdspi_pkg::TRIES_W-1:0]  resp_tries_r;
  logic [BL_W-1:0]                bl_r, bl_nxt;
  logic                           tok_r, tok_nxt;
  logic [1:0]                     crcl_r, crcl_nxt;

  logic [sdspi_pkg::TRIES_W-1:0]  tries_inc;
  logic                           exhausted;
  logic [BL_W-1:0]                bl_dec;
  logic [1:0]                     crcl_dec;
  logic [CMP_W-1:0]               plen_ext;
  logic [CMP_W-1:0]               plen_clamp;
  logic [7:0]                     rx;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= sdspi_pkg::PH_IDLE;
      tries_r      <= '0;
      bl_r         <= '0;
      tok_r        <= 1'b0;
      crcl_r       <= '0;
      resp_tries_r <= sdspi_pkg::RESP_TRIES_RESET;
    end else begin
      phase_r <= phase_nxt;
      tries_r <= tries_nxt;
      bl_r    <= bl_nxt;
      tok_r   <= tok_nxt;
      crcl_r  <= crcl_nxt;
      if (cfg_we) begin
        resp_tries_r <= cfg_wdata;
      end
    end
  end

  assign rx         = item.rx_byte;
  assign tries_inc  = tries_r + 1'b1;
  // a limit of zero acts as one since the incremented count is never below it
  assign exhausted  = tries_inc >= resp_tries_r;
  assign bl_dec     = (bl_r != '0) ? bl_r - 1'b1 : bl_r;
  assign crcl_dec   = (crcl_r != '0) ? crcl_r - 1'b1 : crcl_r;
  assign plen_ext   = CMP_W'(item.payload_len);
  assign plen_clamp = (plen_ext > MAX_CMP) ? MAX_CMP : plen_ext;

  always_comb begin
    phase_nxt = phase_r;
    tries_nxt = tries_r;
    bl_nxt    = bl_r;
    tok_nxt   = tok_r;
    crcl_nxt  = crcl_r;
    batch     = '0;
    if (go) begin
      case (item.op)
        sdspi_pkg::OP_ISSUE: begin
          batch.count = sdspi_pkg::CNT_W'(sdspi_pkg::FRAME_LEN);
          for (int i = 0; i < sdspi_pkg::FRAME_LEN; i++) begin
            batch.words[i].kind = sdspi_pkg::KIND_TX;
            batch.words[i].last = 1'b0;
          end
          batch.words[0].out_byte = sdspi_pkg::CMD_START | {2'b00, item.cmd_index};
          batch.words[1].out_byte = item.cmd_arg[31:24];
          batch.words[2].out_byte = item.cmd_arg[23:16];
          batch.words[3].out_byte = item.cmd_arg[15:8];
          batch.words[4].out_byte = item.cmd_arg[7:0];
          batch.words[5].out_byte = crc_byte;
          batch.words[5].last     = 1'b1;
          phase_nxt = sdspi_pkg::PH_R1;
          tries_nxt = '0;
          bl_nxt    = plen_clamp[BL_W-1:0];
          tok_nxt   = item.with_token;
          crcl_nxt  = '0;
        end
        sdspi_pkg::OP_WRESP: begin
          phase_nxt = sdspi_pkg::PH_DRESP;
          tries_nxt = '0;
          bl_nxt    = '0;
          crcl_nxt  = '0;
        end
        sdspi_pkg::OP_RX: begin
          unique case (phase_r)
            sdspi_pkg::PH_R1: begin
              if ((rx & sdspi_pkg::R1_BUSY_BIT) == '0) begin
                batch.count             = 3'd1;
                batch.words[0].kind     = sdspi_pkg::KIND_R1;
                batch.words[0].out_byte = rx;
                if (bl_r == '0) begin
                  phase_nxt = sdspi_pkg::PH_IDLE;
                end else if (tok_r) begin
                  phase_nxt = sdspi_pkg::PH_TOKEN;
                end else begin
                  phase_nxt = sdspi_pkg::PH_PAYLOAD;
                end
              end else begin
                tries_nxt = tries_inc;
                if (exhausted) begin
                  batch.count         = 3'd1;
                  batch.words[0].kind = sdspi_pkg::KIND_TIMEOUT;
                  phase_nxt           = sdspi_pkg::PH_IDLE;
                end
              end
            end
            sdspi_pkg::PH_TOKEN: begin
              if (rx == sdspi_pkg::DATA_TOKEN) begin
                phase_nxt = sdspi_pkg::PH_PAYLOAD;
              end
            end
            sdspi_pkg::PH_PAYLOAD: begin
              bl_nxt                  = bl_dec;
              batch.count             = 3'd1;
              batch.words[0].kind     = sdspi_pkg::KIND_DATA;
              batch.words[0].out_byte = rx;
              batch.words[0].last     = (bl_dec == '0);
              if (bl_dec == '0) begin
                if (tok_r) begin
                  phase_nxt = sdspi_pkg::PH_CRC;
                  crcl_nxt  = 2'd2;
                end else begin
                  phase_nxt = sdspi_pkg::PH_IDLE;
                end
              end
            end
            sdspi_pkg::PH_CRC: begin
              crcl_nxt = crcl_dec;
              if (crcl_dec == '0) begin
                phase_nxt = sdspi_pkg::PH_IDLE;
              end
            end
            sdspi_pkg::PH_DRESP: begin
              if ((rx & sdspi_pkg::DRESP_MASK) == sdspi_pkg::DRESP_MARK) begin
                if ((rx & sdspi_pkg::DRESP_CODE) != sdspi_pkg::DRESP_OK) begin
                  batch.count             = 3'd1;
                  batch.words[0].kind     = sdspi_pkg::KIND_REJECT;
                  batch.words[0].out_byte = rx;
                  phase_nxt               = sdspi_pkg::PH_IDLE;
                end else begin
                  phase_nxt = sdspi_pkg::PH_BUSY;
                end
              end else begin
                tries_nxt = tries_inc;
                if (exhausted) begin
                  batch.count         = 3'd1;
                  batch.words[0].kind = sdspi_pkg::KIND_TIMEOUT;
                  phase_nxt           = sdspi_pkg::PH_BUSY;
                end
              end
            end
            sdspi_pkg::PH_BUSY: begin
              if (rx != '0) begin
                batch.count         = 3'd1;
                batch.words[0].kind = sdspi_pkg::KIND_DONE;
                phase_nxt           = sdspi_pkg::PH_IDLE;
              end
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

endmodule

/* sv/sdspi_emit.sv */
module sdspi_emit (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  load,
  input  sdspi_pkg::batch_t     batch,
  output logic                  can_load,
  output logic                  out_valid,
  input  logic                  out_ready,
  output sdspi_pkg::out_item_t  out_data
);

  sdspi_pkg::out_item_t [sdspi_pkg::FRAME_LEN-1:0] buf_r;
  logic [sdspi_pkg::CNT_W-1:0]                     cnt_r;
  logic                                            pop;

  assign out_valid = cnt_r != '0;
  assign out_data  = buf_r[0];
  assign pop       = out_valid && out_ready;
  // free now, or the final word leaves this cycle
  assign can_load  = (cnt_r == '0) || ((cnt_r == 3'd1) && out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (load) begin
      cnt_r <= batch.count;
    end else if (pop) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      buf_r <= batch.words;
    end else if (pop) begin
      for (int i = 0; i < sdspi_pkg::FRAME_LEN - 1; i++) begin
        buf_r[i] <= buf_r[i+1];
      end
    end
  end

endmodule

/* sv/sd_spi_command_response_engine_unit.sv */
// channel   ports                         word
// input     in_valid  in_ready  in_data   sdspi_pkg::in_item_t
// result    out_valid out_ready out_data  sdspi_pkg::out_item_t
// config    cfg_we    cfg_wdata           response_tries, 10 bit
//
// A word waits in the input register and is decoded there into 0, 1 or 6
// result words. One word per cycle is taken while results are taken as they come.
// An issue word holds the result buffer until its 6 transmit words have left.
// rst_n is synchronous: phase idle, counters zero, response_tries 200.
// A stalled result side fills the input register, then in_ready drops.
module sd_spi_command_response_engine_unit #(
  parameter int unsigned MAX_PAYLOAD_BYTES = sdspi_pkg::MAX_PAYLOAD_BYTES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  sdspi_pkg::in_item_t            in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output sdspi_pkg::out_item_t           out_data,
  input  logic                           cfg_we,
  input  logic [sdspi_pkg::TRIES_W-1:0]  cfg_wdata
);

`include "sd_spi_command_response_engine_unit_macros.svh"

  sdspi_pkg::in_item_t in_r;
  logic                in_v_r;
  logic                can_load;
  logic                process;
  logic [7:0]          crc_byte;
  sdspi_pkg::batch_t   batch;

  assign process  = in_v_r && can_load;
  assign in_ready = !in_v_r || process;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_v_r <= 1'b1;
    end else if (process) begin
      in_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_r <= in_data;
    end
  end

  sdspi_crc7 u_crc7 (
    .cmd_index (in_r.cmd_index),
    .cmd_arg   (in_r.cmd_arg),
    .crc_byte  (crc_byte)
  );

  sdspi_ctrl #(
    .MAX_PAYLOAD_BYTES (MAX_PAYLOAD_BYTES)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .go        (process),
    .item      (in_r),
    .crc_byte  (crc_byte),
    .batch     (batch)
  );

  sdspi_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (process),
    .batch     (batch),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // last only marks the end of a command frame or of a payload
  `SDSPI_ASSERT_NOW(a_last_kind, out_valid && out_data.last, out_data.kind == sdspi_pkg::KIND_TX || out_data.kind == sdspi_pkg::KIND_DATA)
  // timeout and write done carry no byte
  `SDSPI_ASSERT_NOW(a_status_zero, out_valid && (out_data.kind == sdspi_pkg::KIND_TIMEOUT || out_data.kind == sdspi_pkg::KIND_DONE), out_data.out_byte == 8'h00)
  // a held word is not dropped from the input register
  `SDSPI_ASSERT_NEXT(a_in_hold, in_v_r && !process, in_v_r && $stable(in_r))

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
module testbench;
  import sdspi_pkg::*;

  localparam int QUIET_CYCLES = 16;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int PHASE_WORDS  = 22;

  typedef struct packed {
    logic      has;
    out_item_t word;
  } fixed_t;

  typedef struct {
    logic               is_tries;
    logic [TRIES_W-1:0] tries;
    in_item_t           word;
    fixed_t             fix;
  } plan_row_t;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_ready;
  in_item_t           in_data   = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  out_item_t          out_data;
  logic               cfg_we    = 1'b0;
  logic [TRIES_W-1:0] cfg_wdata = '0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  sd_spi_command_response_engine_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  // engine state as the card side sees it
  phase_t             eng_phase     = PH_IDLE;
  logic [TRIES_W-1:0] eng_tries     = RESP_TRIES_RESET;
  logic [TRIES_W-1:0] eng_used      = '0;
  logic [PLEN_W-1:0]  eng_left      = '0;
  logic               eng_token     = 1'b0;
  logic [1:0]         eng_crc_left  = '0;

  out_item_t step_words[$];
  out_item_t due_words[$];
  fixed_t    fixed_q[$];
  plan_row_t card_plan[$];

  int fail_count  = 0;
  int cycle_count = 0;
  int sent_words  = 0;
  int burst_left  = 0;
  int tries_now   = RESP_TRIES_RESET;

  function automatic logic [7:0] crc7_byte(logic [39:0] msg);
    logic [7:0] acc;
    acc = '0;
    for (int i = 39; i >= 0; i--) begin
      acc = {acc[6:0], 1'b0};
      if (msg[i] ^ acc[7]) begin
        acc = acc ^ CRC7_POLY;
      end
    end
    return {acc[6:0], 1'b1};
  endfunction

  function automatic out_item_t word_of(kind_t k, logic [7:0] b, logic l);
    out_item_t o;
    o.kind     = k;
    o.out_byte = b;
    o.last     = l;
    return o;
  endfunction

  function automatic logic spent_try();
    eng_used = eng_used + 1'b1;
    return eng_used >= eng_tries;
  endfunction

  // results caused by one accepted input word, appended to step_words
  function automatic void engine_step(in_item_t w);
    logic [39:0]       msg;
    logic [PLEN_W-1:0] plen;
    case (w.op)
      OP_ISSUE: begin
        msg = {2'b01, w.cmd_index, w.cmd_arg};
        for (int k = 0; k < 5; k++) begin
          step_words.push_back(word_of(KIND_TX, msg[39 - 8 * k -: 8], 1'b0));
        end
        step_words.push_back(word_of(KIND_TX, crc7_byte(msg), 1'b1));
        plen = (w.payload_len > MAX_PAYLOAD_BYTES_DEF) ?
               PLEN_W'(MAX_PAYLOAD_BYTES_DEF) : w.payload_len;
        eng_phase    = PH_R1;
        eng_used     = '0;
        eng_left     = plen;
        eng_token    = w.with_token;
        eng_crc_left = '0;
      end
      OP_WRESP: begin
        eng_phase    = PH_DRESP;
        eng_used     = '0;
        eng_left     = '0;
        eng_crc_left = '0;
      end
      OP_RX: begin
        case (eng_phase)
          PH_R1: begin
            if (!w.rx_byte[7]) begin
              step_words.push_back(word_of(KIND_R1, w.rx_byte, 1'b0));
              if (eng_left == 0) eng_phase = PH_IDLE;
              else eng_phase = eng_token ? PH_TOKEN : PH_PAYLOAD;
            end else if (spent_try()) begin
              step_words.push_back(word_of(KIND_TIMEOUT, 8'h00, 1'b0));
              eng_phase = PH_IDLE;
            end
          end
          PH_TOKEN: begin
            if (w.rx_byte == DATA_TOKEN) eng_phase = PH_PAYLOAD;
          end
          PH_PAYLOAD: begin
            if (eng_left > 0) eng_left = eng_left - 1'b1;
            step_words.push_back(word_of(KIND_DATA, w.rx_byte, eng_left == 0));
            if (eng_left == 0) begin
              if (eng_token) begin
                eng_phase    = PH_CRC;
                eng_crc_left = 2'd2;
              end else begin
                eng_phase = PH_IDLE;
              end
            end
          end
          PH_CRC: begin
            if (eng_crc_left > 0) eng_crc_left = eng_crc_left - 1'b1;
            if (eng_crc_left == 0) eng_phase = PH_IDLE;
          end
          PH_DRESP: begin
            if ((w.rx_byte & DRESP_MASK) == DRESP_MARK) begin
              if ((w.rx_byte & DRESP_CODE) != DRESP_OK) begin
                step_words.push_back(word_of(KIND_REJECT, w.rx_byte, 1'b0));
                eng_phase = PH_IDLE;
              end else begin
                eng_phase = PH_BUSY;
              end
            end else if (spent_try()) begin
              step_words.push_back(word_of(KIND_TIMEOUT, 8'h00, 1'b0));
              eng_phase = PH_BUSY;
            end
          end
          PH_BUSY: begin
            if (w.rx_byte != 8'h00) begin
              step_words.push_back(word_of(KIND_DONE, 8'h00, 1'b0));
              eng_phase = PH_IDLE;
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  endfunction

  always @(posedge clk) begin
    fixed_t    fx;
    out_item_t want;
    if (!rst_n) begin
      eng_phase    = PH_IDLE;
      eng_tries    = RESP_TRIES_RESET;
      eng_used     = '0;
      eng_left     = '0;
      eng_token    = 1'b0;
      eng_crc_left = '0;
    end else begin
      if (cfg_we) eng_tries = cfg_wdata;
      if (in_valid && in_ready) begin
        step_words.delete();
        engine_step(in_data);
        fx = fixed_q.pop_front();
        if (fx.has) due_words.push_back(fx.word);
        else foreach (step_words[k]) due_words.push_back(step_words[k]);
      end
      if (out_valid && out_ready) begin
        if (due_words.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected word, expected none, got kind %0d byte %h last %b",
                   $time, out_data.kind, out_data.out_byte, out_data.last);
        end else begin
          want = due_words.pop_front();
          if (out_data.kind !== want.kind) begin
            fail_count++;
            $display("%0t: kind expected %0d got %0d", $time, want.kind, out_data.kind);
          end
          if (out_data.out_byte !== want.out_byte) begin
            fail_count++;
            $display("%0t: byte expected %h got %h", $time, want.out_byte,
                     out_data.out_byte);
          end
          if (out_data.last !== want.last) begin
            fail_count++;
            $display("%0t: last expected %b got %b", $time, want.last, out_data.last);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // result side: the stall style is drawn at random from four modes
  int   rx_tick    = 0;
  int   stall_mode = 0;
  int   run_left   = 0;
  logic run_high   = 1'b1;

  always @(negedge clk) begin
    logic go;
    rx_tick++;
    if (rx_tick % 128 == 0) stall_mode = $urandom_range(0, 3);
    case (stall_mode)
      0: go = 1'b1;
      1: go = 1'($urandom_range(0, 1));
      2: begin
        if (run_left == 0) begin
          run_high = ~run_high;
          run_left = $urandom_range(1, 7);
        end
        run_left--;
        go = run_high;
      end
      default: go = (rx_tick % 4) != 0;
    endcase
    out_ready <= go;
  end

  function automatic in_item_t rand_word(op_t op);
    in_item_t w;
    w.op          = op;
    w.cmd_index   = 6'($urandom_range(0, 63));
    w.cmd_arg     = $urandom;
    w.payload_len = PLEN_W'($urandom_range(0, 1023));
    w.with_token  = 1'($urandom_range(0, 1));
    w.rx_byte     = 8'($urandom_range(0, 255));
    return w;
  endfunction

  function automatic in_item_t rx_word(logic [7:0] b);
    in_item_t w;
    w = rand_word(OP_RX);
    w.rx_byte = b;
    return w;
  endfunction

  function automatic in_item_t issue_word(logic [5:0] idx, logic [31:0] arg,
                                          logic [PLEN_W-1:0] plen, logic tok);
    in_item_t w;
    w = rand_word(OP_ISSUE);
    w.cmd_index   = idx;
    w.cmd_arg     = arg;
    w.payload_len = plen;
    w.with_token  = tok;
    return w;
  endfunction

  function automatic void add_word(in_item_t w);
    plan_row_t r;
    r.is_tries = 1'b0;
    r.tries    = '0;
    r.word     = w;
    r.fix      = '0;
    card_plan.push_back(r);
  endfunction

  function automatic void add_fixed(in_item_t w, kind_t k, logic [7:0] b, logic l);
    plan_row_t r;
    r.is_tries = 1'b0;
    r.tries    = '0;
    r.word     = w;
    r.fix.has  = 1'b1;
    r.fix.word = word_of(k, b, l);
    card_plan.push_back(r);
  endfunction

  function automatic void add_tries(logic [TRIES_W-1:0] v);
    plan_row_t r;
    r.is_tries = 1'b1;
    r.tries    = v;
    r.word     = '0;
    r.fix      = '0;
    card_plan.push_back(r);
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic push_word(in_item_t w, fixed_t fx);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    fixed_q.push_back(fx);
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    sent_words++;
    @(negedge clk);
  endtask

  task automatic send_rx(logic [7:0] b);
    push_word(rx_word(b), '0);
  endtask

  // a byte that is no data-response token
  task automatic send_stray_dresp();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while ((b & DRESP_MASK) == DRESP_MARK);
    send_rx(b);
  endtask

  task automatic set_tries(logic [TRIES_W-1:0] v);
    in_valid <= 1'b0;
    while (due_words.size() != 0) @(negedge clk);
    repeat (QUIET_CYCLES) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
    tries_now = v;
  endtask

  // sel 0: read command, 1: write response, other: noise
  task automatic card_exchange(int sel, bit force_timeout, bit force_big);
    in_item_t   w;
    logic [7:0] b;
    int         eff;
    int         pre;
    int         plen;
    int         n;
    bit         abandon;
    eff = (tries_now == 0) ? 1 : tries_now;
    abandon = 1'b0;
    case (sel)
      0: begin
        w = rand_word(OP_ISSUE);
        if (force_big) begin
          // oversized length, dropped after at most 6 payload bytes
          w.payload_len = PLEN_W'($urandom_range(513, 1023));
          abandon = 1'b1;
        end else begin
          case ($urandom_range(0, 5))
            0: w.payload_len = '0;
            1: begin
              w.payload_len = PLEN_W'($urandom_range(1, 1023));
              abandon = 1'b1;
            end
            default: w.payload_len = PLEN_W'($urandom_range(1, 8));
          endcase
        end
        push_word(w, '0);
        plen = (w.payload_len > MAX_PAYLOAD_BYTES_DEF) ? MAX_PAYLOAD_BYTES_DEF :
               int'(w.payload_len);
        if (force_timeout || (eff <= 16 && $urandom_range(0, 4) == 0)) begin
          repeat (eff) send_rx(8'h80 | 8'($urandom_range(0, 127)));
        end else begin
          pre = $urandom_range(0, (eff - 1 < 3) ? eff - 1 : 3);
          repeat (pre) send_rx(8'h80 | 8'($urandom_range(0, 127)));
          send_rx(8'($urandom_range(0, 127)));
          if (plen > 0) begin
            if (w.with_token) begin
              repeat ($urandom_range(0, 3)) begin
                do b = 8'($urandom_range(0, 255)); while (b == DATA_TOKEN);
                send_rx(b);
              end
              send_rx(DATA_TOKEN);
            end
            n = abandon ? $urandom_range(0, (plen < 6) ? plen : 6) : plen;
            repeat (n) send_rx(8'($urandom_range(0, 255)));
            if (w.with_token && !abandon) repeat (2) send_rx(8'($urandom_range(0, 255)));
          end
        end
      end
      1: begin
        push_word(rand_word(OP_WRESP), '0);
        pre = $urandom_range(0, (eff - 1 < 3) ? eff - 1 : 3);
        repeat (pre) send_stray_dresp();
        case ($urandom_range(0, 3))
          0: begin
            do begin
              b = 8'($urandom_range(0, 255));
              b[0] = 1'b1;
              b[4] = 1'b0;
            end while (b[4:0] == DRESP_OK[4:0]);
            send_rx(b);
            abandon = 1'b1;
          end
          1: begin
            if (eff <= 16) begin
              repeat (eff) send_stray_dresp();
            end else begin
              b = 8'($urandom_range(0, 255));
              b[4:0] = DRESP_OK[4:0];
              send_rx(b);
            end
          end
          default: begin
            b = 8'($urandom_range(0, 255));
            b[4:0] = DRESP_OK[4:0];
            send_rx(b);
          end
        endcase
        // rejected tokens end the exchange, the rest go through the busy wait
        if (!abandon) begin
          repeat ($urandom_range(0, 4)) send_rx(8'h00);
          send_rx(8'($urandom_range(1, 255)));
        end
      end
      default: begin
        repeat ($urandom_range(1, 6)) push_word(rand_word(op_t'($urandom_range(0, 3))), '0);
      end
    endcase
  endtask

  initial begin
    in_item_t    w;
    int unsigned tries_seq[4];
    int          start;
    int          roll;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    add_word(rx_word(8'h00));                       // stray byte while idle
    w = '1;
    add_word(w);                                    // no-op word
    add_word(issue_word(6'd0, 32'h0000_0000, 10'd0, 1'b0));
    add_word(rx_word(8'hff));
    add_fixed(rx_word(8'h00), KIND_R1, 8'h00, 1'b0);
    add_word(issue_word(6'd63, 32'hffff_ffff, 10'd2, 1'b1));
    add_fixed(rx_word(8'h7f), KIND_R1, 8'h7f, 1'b0); // error bits, payload still follows
    add_word(rx_word(8'h00));
    add_word(rx_word(DATA_TOKEN));
    add_fixed(rx_word(8'hab), KIND_DATA, 8'hab, 1'b0);
    add_fixed(rx_word(8'hff), KIND_DATA, 8'hff, 1'b1);
    add_word(rx_word(8'h12));                       // two crc bytes dropped
    add_word(rx_word(8'h34));
    add_word(rand_word(OP_WRESP));
    add_fixed(rx_word(8'h0b), KIND_REJECT, 8'h0b, 1'b0);
    add_word(rand_word(OP_WRESP));
    add_word(rx_word(8'he5));
    add_word(rx_word(8'h00));
    add_fixed(rx_word(8'h01), KIND_DONE, 8'h00, 1'b0);
    add_word(issue_word(6'd17, 32'h1234_5678, 10'd1, 1'b0));
    add_word(rand_word(OP_WRESP));                  // abandons the R1 wait
    add_word(issue_word(6'd8, 32'h0000_01aa, 10'd0, 1'b0));
    add_fixed(rx_word(8'h01), KIND_R1, 8'h01, 1'b0);
    add_tries(10'd1);
    add_word(issue_word(6'd55, 32'h0000_0000, 10'd0, 1'b0));
    add_fixed(rx_word(8'hff), KIND_TIMEOUT, 8'h00, 1'b0);
    add_word(rand_word(OP_WRESP));
    add_fixed(rx_word(8'hff), KIND_TIMEOUT, 8'h00, 1'b0);
    add_fixed(rx_word(8'h80), KIND_DONE, 8'h00, 1'b0);
    add_tries(10'd0);                               // zero tries acts as one
    add_word(rand_word(OP_WRESP));
    add_fixed(rx_word(8'h00), KIND_TIMEOUT, 8'h00, 1'b0);
    add_fixed(rx_word(8'h55), KIND_DONE, 8'h00, 1'b0);

    foreach (card_plan[i]) begin
      if (card_plan[i].is_tries) set_tries(card_plan[i].tries);
      else push_word(card_plan[i].word, card_plan[i].fix);
    end

    tries_seq[0] = 1023;
    tries_seq[1] = $urandom_range(2, 6);
    tries_seq[2] = $urandom_range(1, 12);
    tries_seq[3] = RESP_TRIES_RESET;
    foreach (tries_seq[p]) begin
      set_tries(TRIES_W'(tries_seq[p]));
      if (tries_seq[p] <= 16) card_exchange(0, 1'b1, 1'b0);
      if (tries_seq[p] == RESP_TRIES_RESET) card_exchange(0, 1'b0, 1'b1);
      start = sent_words;
      while (sent_words - start < PHASE_WORDS) begin
        roll = $urandom_range(0, 9);
        card_exchange((roll < 5) ? 0 : (roll < 8) ? 1 : 2, 1'b0, 1'b0);
      end
    end

    in_valid <= 1'b0;
    while (due_words.size() != 0) @(negedge clk);
    repeat (QUIET_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
